@@ hw/rtl/acfm_pkg.sv @@
// Shared types, constants and helper functions for the adaptive context frequency model.
package acfm_pkg;

  localparam int unsigned CONTEXTS   = 2048;
  localparam int unsigned SYMBOLS    = 8;
  localparam int unsigned CTX_W      = $clog2(CONTEXTS);
  localparam int unsigned SYM_W      = $clog2(SYMBOLS);
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned CDF_W      = 16;
  localparam int unsigned CUM_W      = 17;
  localparam int unsigned PROB_ONE   = 65536;
  localparam int unsigned SCALE      = PROB_ONE - SYMBOLS;
  localparam int unsigned DIVD_W     = CNT_W + CDF_W;
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_CYCLES = CDF_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);
  localparam int unsigned SUM_W      = CNT_W + SYM_W;

  localparam logic [CNT_W-1:0] HALVE_LIMIT_RESET = CNT_W'(640);

  typedef struct packed {
    logic [CTX_W-1:0] context_index;
    logic [SYM_W-1:0] symbol_value;
    logic             refresh_cdf;
  } in_item_t;

  typedef struct packed {
    logic [CDF_W-1:0] cum_low;
    logic [CUM_W-1:0] cum_high;
  } out_item_t;

  typedef logic [SYMBOLS-1:0][CNT_W-1:0] cnt_row_t;
  typedef logic [SYMBOLS-1:0][CDF_W-1:0] cdf_row_t;

  typedef enum logic [8:0] {
    ST_CLEAR     = 9'b000000001,
    ST_IDLE      = 9'b000000010,
    ST_READ      = 9'b000000100,
    ST_UPDATE    = 9'b000001000,
    ST_HALVE     = 9'b000010000,
    ST_WRITE     = 9'b000100000,
    ST_DIV_START = 9'b001000000,
    ST_DIV_RUN   = 9'b010000000,
    ST_CDF_WRITE = 9'b100000000
  } state_e;

  typedef struct packed {
    logic clr_write;
    logic idle;
    logic latch;
    logic mem_read;
    logic update;
    logic halve;
    logic mem_write;
    logic div_start;
    logic div_store;
    logic cdf_write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic refresh;
    logic last_entry;
    logic div_done;
    logic cum_match;
  } dp_status_t;

  function automatic cnt_row_t cnt_reset_row();
    cnt_row_t row;
    for (int k = 0; k < SYMBOLS; k++) begin
      row[k] = CNT_W'(1);
    end
    return row;
  endfunction

  function automatic cdf_row_t cdf_reset_row();
    cdf_row_t row;
    for (int k = 0; k < SYMBOLS; k++) begin
      row[k] = CDF_W'(k * (PROB_ONE / SYMBOLS));
    end
    return row;
  endfunction

endpackage

@@ hw/rtl/adaptive_context_frequency_model_unit.sv @@
// Top level of the adaptive context frequency model.
// Each transaction on the input channel names a context, a symbol and a refresh flag, and
// yields one result transaction with the symbol's low and high cumulative bounds taken from
// that context's CDF before the update. One item is processed at a time: the next item is
// taken only after the current one has been written back; with refresh the CDF rebuild
// runs first, using the shared divider once for each of the seven non-zero CDF entries.
// The result sits in an output register, so the next item is accepted while a result is
// still stalled. After reset a clearing pass (one context row per cycle) initializes the
// memories; no input is accepted during it, while halve_limit writes are taken at any time.
module adaptive_context_frequency_model_unit
  import acfm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  state_e     state;

  acfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  acfm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o  = ~cmd.idle;
  assign cfg_ready_o = 1'b1;

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state == ST_READ))
    else $error("accepted transaction did not start a context read");

  a_rebuild_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == ST_CDF_WRITE) |-> status.cum_match)
    else $error("symbol counts do not add up to the context total");

  a_div_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> (state == ST_DIV_RUN))
    else $error("divider finished outside of a rebuild step");

  a_clear_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == ST_CLEAR) |-> !out_valid_o)
    else $error("result presented during clearing pass");

endmodule

@@ hw/rtl/acfm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module acfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/acfm_div.sv @@
// Iterative divider, four quotient bits per cycle, for the CDF rebuild.
module acfm_div
  import acfm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [CDF_W-1:0]  quotient_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0]     rem_q, divisor_q, rem_d;
  logic [CDF_W-1:0]     shift_q, shift_d;

  // quotient fits in CDF_W bits since the running sum stays below the total
  always_comb begin
    logic [CNT_W:0] t;
    rem_d   = rem_q;
    shift_d = shift_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {rem_d, shift_d[CDF_W-1]};
      if (t >= {1'b0, divisor_q}) begin
        rem_d   = CNT_W'(t - {1'b0, divisor_q});
        shift_d = {shift_d[CDF_W-2:0], 1'b1};
      end else begin
        rem_d   = t[CNT_W-1:0];
        shift_d = {shift_d[CDF_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= dividend_i[DIVD_W-1:CDF_W];
      shift_q   <= dividend_i[CDF_W-1:0];
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q   <= rem_d;
      shift_q <= shift_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shift_q;

endmodule

@@ hw/rtl/acfm_ctrl.sv @@
// Controller state machine: clearing pass, item sequencing and CDF rebuild steps.
module acfm_ctrl
  import acfm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o,
  output state_e     state_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = ST_HALVE;
        end
      end
      ST_HALVE: begin
        cmd_o.halve = 1'b1;
        state_d     = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.mem_write = 1'b1;
        state_d         = status_i.refresh ? ST_DIV_START : ST_IDLE;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (status_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_d         = status_i.last_entry ? ST_CDF_WRITE : ST_DIV_START;
        end
      end
      ST_CDF_WRITE: begin
        cmd_o.cdf_write = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

@@ hw/rtl/acfm_dp.sv @@
// Datapath: context memories, count update and halving, CDF rebuild and output register.
module acfm_dp
  import acfm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  input  in_item_t         in_data_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output out_item_t        out_data_o
);

  in_item_t         item_q;
  logic [CTX_W-1:0] clr_addr_q;
  logic [CNT_W-1:0] halve_limit_q;
  cnt_row_t         counts_q;
  logic [CNT_W-1:0] total_q;
  logic [CNT_W-1:0] cum_q;
  cdf_row_t         cdf_q;
  logic [SYM_W-1:0] k_q;
  out_item_t        out_q;
  logic             out_valid_q;

  logic [CTX_W-1:0]  wr_addr;
  cnt_row_t          cnt_wdata, cnt_rdata, cnt_inc, cnt_half;
  logic [CNT_W-1:0]  tot_wdata, tot_rdata;
  cdf_row_t          cdf_wdata, cdf_rdata;
  logic [SYM_W-1:0]  sym, sym_next;
  logic [SUM_W-1:0]  half_sum;
  logic [CNT_W:0]    half_tmp;
  logic              halve_hit;
  logic              out_free;
  logic [DIVD_W-1:0] dividend;
  logic              div_done;
  logic [CDF_W-1:0]  quotient;
  out_item_t         out_d;

  assign wr_addr   = cmd_i.clr_write ? clr_addr_q : item_q.context_index;
  assign cnt_wdata = cmd_i.clr_write ? cnt_reset_row() : counts_q;
  assign tot_wdata = cmd_i.clr_write ? CNT_W'(SYMBOLS) : total_q;
  assign cdf_wdata = cmd_i.clr_write ? cdf_reset_row() : cdf_q;

  acfm_ram #(.WIDTH($bits(cnt_row_t)), .DEPTH(CONTEXTS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_write | cmd_i.mem_write),
    .waddr_i (wr_addr),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.mem_read),
    .raddr_i (item_q.context_index),
    .rdata_o (cnt_rdata)
  );

  acfm_ram #(.WIDTH(CNT_W), .DEPTH(CONTEXTS)) u_tot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_write | cmd_i.mem_write),
    .waddr_i (wr_addr),
    .wdata_i (tot_wdata),
    .re_i    (cmd_i.mem_read),
    .raddr_i (item_q.context_index),
    .rdata_o (tot_rdata)
  );

  acfm_ram #(.WIDTH($bits(cdf_row_t)), .DEPTH(CONTEXTS)) u_cdf_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_write | cmd_i.cdf_write),
    .waddr_i (wr_addr),
    .wdata_i (cdf_wdata),
    .re_i    (cmd_i.mem_read),
    .raddr_i (item_q.context_index),
    .rdata_o (cdf_rdata)
  );

  assign sym      = item_q.symbol_value;
  assign sym_next = sym + SYM_W'(1);

  always_comb begin
    cnt_inc      = cnt_rdata;
    cnt_inc[sym] = cnt_rdata[sym] + CNT_W'(1);
  end

  always_comb begin
    half_sum = '0;
    half_tmp = '0;
    for (int k = 0; k < SYMBOLS; k++) begin
      half_tmp    = {1'b0, counts_q[k]} + (CNT_W+1)'(1);
      cnt_half[k] = half_tmp[CNT_W:1];
      half_sum    = half_sum + SUM_W'(cnt_half[k]);
    end
  end

  assign halve_hit = (total_q >= halve_limit_q);

  always_comb begin
    out_d.cum_low = cdf_rdata[sym];
    if (sym == SYM_W'(SYMBOLS - 1)) begin
      out_d.cum_high = CUM_W'(PROB_ONE);
    end else begin
      out_d.cum_high = {1'b0, cdf_rdata[sym_next]};
    end
  end

  assign dividend = DIVD_W'(cum_q) * DIVD_W'(SCALE);

  acfm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q    <= '0;
      halve_limit_q <= HALVE_LIMIT_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.clr_write) begin
        clr_addr_q <= clr_addr_q + CTX_W'(1);
      end
      if (cfg_we_i) begin
        halve_limit_q <= cfg_data_i;
      end
      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
    end
    if (cmd_i.update) begin
      out_q    <= out_d;
      counts_q <= cnt_inc;
      total_q  <= tot_rdata + CNT_W'(1);
    end
    if (cmd_i.halve && halve_hit) begin
      counts_q <= cnt_half;
      total_q  <= half_sum[CNT_W-1:0];
    end
    if (cmd_i.mem_write) begin
      cdf_q[0] <= '0;
      cum_q    <= counts_q[0];
      k_q      <= SYM_W'(1);
    end
    if (cmd_i.div_store) begin
      cdf_q[k_q] <= quotient + CDF_W'(k_q);
      cum_q      <= cum_q + counts_q[k_q];
      k_q        <= k_q + SYM_W'(1);
    end
  end

  assign status_o.clr_last   = (clr_addr_q == CTX_W'(CONTEXTS - 1));
  assign status_o.out_free   = out_free;
  assign status_o.refresh    = item_q.refresh_cdf && (total_q != '0);
  assign status_o.last_entry = (k_q == SYM_W'(SYMBOLS - 1));
  assign status_o.div_done   = div_done;
  assign status_o.cum_match  = (cum_q == total_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
